>>> rtl/core/rc4_pkg.sv
// rc4 cipher package: state encoding, request struct and shared constants
// no dependencies; imported by rc4_stream_cipher, rc4_perm and rc4_seq
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PERM_DEPTH  = 256;
  localparam int unsigned KEY_MAX_DEF = 256;

  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_WN,
    ST_KS_WJ,
    ST_PR_I,
    ST_PR_J,
    ST_PR_WI,
    ST_PR_WJ,
    ST_PR_T,
    ST_PR_OUT
  } rc4_state_e;

  typedef struct packed {
    logic              clear;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_addr;
    logic              wr_en;
    logic [BYTE_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
  } perm_req_t;

endpackage

`default_nettype wire

>>> rtl/core/rc4_stream_cipher.sv
// rc4 stream cipher top: key bytes are stored; the last key byte also starts the key
// schedule, each swap step passing the read, j, write-n and write-j states
// data byte: states i, j, wi, wj, t and out; busy until the result is registered
// reset: permutation reads as identity at once via per-entry valid bits, indices and
// key count cleared, no clearing pass; key store contents undefined until written
// depends on rc4_pkg, rc4_ram, rc4_perm, rc4_seq
`timescale 1ns / 1ps
`default_nettype none

module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_MAX = KEY_MAX_DEF,
  localparam int unsigned KIW    = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] byte_in
  input  wire logic              s_axis_tuser,   // [0] func
  input  wire logic              s_axis_tlast,   // key_last
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [BYTE_W-1:0] m_axis_tdata    // [7:0] byte_out
);

  perm_req_t         perm_req;
  logic [BYTE_W-1:0] perm_rdata;
  logic              key_we;
  logic [KIW-1:0]    key_waddr;
  logic [BYTE_W-1:0] key_wdata;
  logic              key_re;
  logic [KIW-1:0]    key_raddr;
  logic [BYTE_W-1:0] key_rdata;

  rc4_seq #(
    .KEY_MAX (KEY_MAX)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_func_i    (s_axis_tuser),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .perm_req_o   (perm_req),
    .perm_rdata_i (perm_rdata),
    .key_we_o     (key_we),
    .key_waddr_o  (key_waddr),
    .key_wdata_o  (key_wdata),
    .key_re_o     (key_re),
    .key_raddr_o  (key_raddr),
    .key_rdata_i  (key_rdata)
  );

  rc4_perm u_perm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (perm_req),
    .rdata_o (perm_rdata)
  );

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (KEY_MAX)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  // plain key byte leaves the engine ready again in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_KEY && !s_axis_tlast
    |=> s_axis_tready)
    else $error("key byte request did not return to ready");

  // data byte or last key byte keeps the engine busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_DATA || s_axis_tlast)
    |=> !s_axis_tready)
    else $error("engine ready right after a multi-cycle request");

  // a result only appears at the end of a keystream step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while engine was idle");

endmodule

`default_nettype wire

>>> rtl/core/rc4_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rc4_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/rc4_perm.sv
// permutation store: ram plus per-entry valid bits, unwritten entries read as their index
// depends on rc4_pkg and rc4_ram
`timescale 1ns / 1ps
`default_nettype none

module rc4_perm
  import rc4_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire perm_req_t         req_i,
  output logic      [BYTE_W-1:0] rdata_o
);

  logic [PERM_DEPTH-1:0] valid_q;
  logic                  rd_hit_q;
  logic [BYTE_W-1:0]     rd_addr_q;
  logic [BYTE_W-1:0]     ram_rdata;

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PERM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.wr_en),
    .waddr_i (req_i.wr_addr),
    .wdata_i (req_i.wr_data),
    .re_i    (req_i.rd_en),
    .raddr_i (req_i.rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.clear) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_hit_q  <= valid_q[req_i.rd_addr];
      rd_addr_q <= req_i.rd_addr;
    end
  end

  assign rdata_o = rd_hit_q ? ram_rdata : rd_addr_q;

endmodule

`default_nettype wire

>>> rtl/core/rc4_seq.sv
// rc4 sequencer: key loading, key schedule and keystream steps over one shared adder
// depends on rc4_pkg
`timescale 1ns / 1ps
`default_nettype none

module rc4_seq
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_MAX = KEY_MAX_DEF,
  localparam int unsigned KIW    = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1,
  localparam int unsigned CW     = $clog2(KEY_MAX + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              in_func_i,
  input  wire logic [BYTE_W-1:0] in_byte_i,
  input  wire logic              in_last_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [BYTE_W-1:0] out_byte_o,
  output perm_req_t              perm_req_o,
  input  wire logic [BYTE_W-1:0] perm_rdata_i,
  output logic                   key_we_o,
  output logic      [KIW-1:0]    key_waddr_o,
  output logic      [BYTE_W-1:0] key_wdata_o,
  output logic                   key_re_o,
  output logic      [KIW-1:0]    key_raddr_o,
  input  wire logic [BYTE_W-1:0] key_rdata_i
);

  rc4_state_e state_q, state_d;

  logic [CW-1:0]     key_count_q, key_count_d;
  logic [KIW-1:0]    kp_q, kp_d, kp_last;
  logic [BYTE_W-1:0] n_q, n_d;
  logic [BYTE_W-1:0] i_q, i_d;
  logic [BYTE_W-1:0] j_q, j_d;
  logic [BYTE_W-1:0] a_q, a_d;
  logic [BYTE_W-1:0] b_q, b_d;
  logic [BYTE_W-1:0] data_q, data_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              in_acc;
  logic              out_free;
  logic [BYTE_W-1:0] sum;
  logic [BYTE_W-1:0] sum_b;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;
  assign kp_last  = (key_count_q == '0) ? '0 : KIW'(key_count_q - CW'(1));

  // shared adder, operand b selects key byte during the schedule
  assign sum_b = (state_q == ST_KS_J) ? key_rdata_i : '0;
  always_comb begin
    case (state_q)
      ST_PR_T: sum = a_q + b_q;
      default: sum = j_q + perm_rdata_i + sum_b;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_func_i == FUNC_DATA) begin
            state_d = ST_PR_I;
          end else if (in_last_i) begin
            state_d = ST_KS_RD;
          end
        end
      end
      ST_KS_RD: state_d = ST_KS_J;
      ST_KS_J:  state_d = ST_KS_WN;
      ST_KS_WN: state_d = ST_KS_WJ;
      ST_KS_WJ: state_d = (n_q == '1) ? ST_IDLE : ST_KS_RD;
      ST_PR_I:  state_d = ST_PR_J;
      ST_PR_J:  state_d = ST_PR_WI;
      ST_PR_WI: state_d = ST_PR_WJ;
      ST_PR_WJ: state_d = ST_PR_T;
      ST_PR_T:  state_d = ST_PR_OUT;
      ST_PR_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    perm_req_o  = '0;
    key_we_o    = 1'b0;
    key_waddr_o = KIW'(key_count_q);
    key_wdata_o = in_byte_i;
    key_re_o    = 1'b0;
    key_raddr_o = kp_q;
    key_count_d = key_count_q;
    kp_d        = kp_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    a_d         = a_q;
    b_d         = b_q;
    data_d      = data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          if (in_func_i == FUNC_DATA) begin
            i_d    = i_q + 8'd1;
            data_d = in_byte_i;
          end else begin
            if (key_count_q < CW'(KEY_MAX)) begin
              key_we_o    = 1'b1;
              key_count_d = key_count_q + CW'(1);
            end
            if (in_last_i) begin
              perm_req_o.clear = 1'b1;
              n_d  = '0;
              j_d  = '0;
              kp_d = '0;
            end
          end
        end
      end
      ST_KS_RD: begin
        perm_req_o.rd_en   = 1'b1;
        perm_req_o.rd_addr = n_q;
        key_re_o           = 1'b1;
      end
      ST_KS_J: begin
        a_d                = perm_rdata_i;
        j_d                = sum;
        perm_req_o.rd_en   = 1'b1;
        perm_req_o.rd_addr = sum;
      end
      ST_KS_WN: begin
        perm_req_o.wr_en   = 1'b1;
        perm_req_o.wr_addr = n_q;
        perm_req_o.wr_data = perm_rdata_i;
      end
      ST_KS_WJ: begin
        perm_req_o.wr_en   = 1'b1;
        perm_req_o.wr_addr = j_q;
        perm_req_o.wr_data = a_q;
        n_d  = n_q + 8'd1;
        kp_d = (kp_q == kp_last) ? '0 : kp_q + KIW'(1);
        if (n_q == '1) begin
          i_d         = '0;
          j_d         = '0;
          key_count_d = '0;
        end
      end
      ST_PR_I: begin
        perm_req_o.rd_en   = 1'b1;
        perm_req_o.rd_addr = i_q;
      end
      ST_PR_J: begin
        a_d                = perm_rdata_i;
        j_d                = sum;
        perm_req_o.rd_en   = 1'b1;
        perm_req_o.rd_addr = sum;
      end
      ST_PR_WI: begin
        b_d                = perm_rdata_i;
        perm_req_o.wr_en   = 1'b1;
        perm_req_o.wr_addr = i_q;
        perm_req_o.wr_data = perm_rdata_i;
      end
      ST_PR_WJ: begin
        perm_req_o.wr_en   = 1'b1;
        perm_req_o.wr_addr = j_q;
        perm_req_o.wr_data = a_q;
      end
      ST_PR_T: begin
        perm_req_o.rd_en   = 1'b1;
        perm_req_o.rd_addr = sum;
      end
      ST_PR_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = data_q ^ perm_rdata_i;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_count_q <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_count_q <= key_count_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kp_q       <= kp_d;
    n_q        <= n_d;
    a_q        <= a_d;
    b_q        <= b_d;
    data_q     <= data_d;
    out_byte_q <= out_byte_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

endmodule

`default_nettype wire
